>>> rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants of the resolve retry table: command codes,
// sequencer states, the table entry layout and the result beat layout.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned LIMIT_W = 21;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned MS_W    = 32;

  // delay (s) times ms per second stays below 2^42
  localparam int unsigned PROD_W     = 42;
  localparam int unsigned MS_PER_SEC = 1000;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(16);
  localparam logic [DELAY_W-1:0] DELAY_INIT = DELAY_W'(1);
  localparam logic [DELAY_W-1:0] DELAY_MAX  = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_COMPLETE = 3'd1,
    CMD_MARK     = 3'd2,
    CMD_NEXT     = 3'd3,
    CMD_UNTIL    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE
  } state_e;

  // one table slot as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]    node;
    logic [ID_W-1:0]    fabric;
    logic [TIME_W-1:0]  due;
    logic [DELAY_W-1:0] delay;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic               rv;
    logic               flag;
    logic [MS_W-1:0]    delay_ms;
    logic [ID_W-1:0]    node;
    logic [ID_W-1:0]    fabric;
  } res_t;

endpackage

>>> rtl/rrt_ram.sv
// ----------------------------------------------------------------------------
// rrt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rrt_engine.sv
// ----------------------------------------------------------------------------
// rrt_engine
// Command sequencer: latches one command, scans the table RAM one entry per
// cycle, then writes back the chosen entry and hands over one result.
// ----------------------------------------------------------------------------
module rrt_engine
  import rrt_pkg::*;
#(
  parameter int unsigned ENTRIES = 4,
  localparam int unsigned IW     = $clog2(ENTRIES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command beat
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   in_cmd_i,
  input  logic [ID_W-1:0]    in_node_i,
  input  logic [ID_W-1:0]    in_fabric_i,
  input  logic [TIME_W-1:0]  in_now_i,
  input  logic [LIMIT_W-1:0] limit_i,
  // result handover
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o,
  // table RAM
  output logic [IW-1:0]      rd_addr_o,
  input  entry_t             rd_data_i,
  output logic               wr_en_o,
  output logic [IW-1:0]      wr_addr_o,
  output entry_t             wr_data_o
);

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [ID_W-1:0]     node_q, node_d;
  logic [ID_W-1:0]     fab_q, fab_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [IW-1:0]       eidx_q, eidx_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic                hit_q, hit_d;
  logic [IW-1:0]       hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IW-1:0]       free_idx_q, free_idx_d;
  logic                od_q, od_d;
  logic [IW-1:0]       best_idx_q, best_idx_d;
  logic [DELAY_W-1:0]  best_delay_q, best_delay_d;
  logic [TIME_W-1:0]   best_due_q, best_due_d;
  logic [ID_W-1:0]     ent_node_q, ent_node_d;
  logic [ID_W-1:0]     ent_fab_q, ent_fab_d;
  logic [PROD_W-1:0]   prod_q, prod_d;

  logic                ent_used;
  logic                ent_match;
  logic [TIME_W:0]     diff;
  logic                ent_due;
  logic [IW-1:0]       mark_slot;
  logic [DELAY_W-1:0]  delay_next;

  // per-entry checks on the word read back from the RAM
  assign ent_used  = valid_q[eidx_q];
  assign ent_match = ent_used && (node_q != '0) && (rd_data_i.node == node_q) &&
                     (rd_data_i.fabric == fab_q);
  assign diff      = {1'b0, rd_data_i.due} - {1'b0, now_q};
  assign ent_due   = diff[TIME_W] || (diff[TIME_W-1:0] == '0);

  assign mark_slot  = hit_q ? hit_idx_q : (free_q ? free_idx_q : best_idx_q);
  assign delay_next = best_delay_q[DELAY_W-1] ? DELAY_MAX :
                      {best_delay_q[DELAY_W-2:0], 1'b0};

  assign in_ready_o = (state_q == ST_IDLE);
  assign rd_addr_o  = (state_q == ST_SCAN) ? eidx_q + IW'(1) : '0;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // command and scan registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    node_q       <= node_d;
    fab_q        <= fab_d;
    now_q        <= now_d;
    eidx_q       <= eidx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    od_q         <= od_d;
    best_idx_q   <= best_idx_d;
    best_delay_q <= best_delay_d;
    best_due_q   <= best_due_d;
    ent_node_q   <= ent_node_d;
    ent_fab_q    <= ent_fab_d;
    prod_q       <= prod_d;
  end

  // sequencer: accept, scan, reschedule product, write back
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    node_d       = node_q;
    fab_d        = fab_q;
    now_d        = now_q;
    eidx_d       = eidx_q;
    valid_d      = valid_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    od_d         = od_q;
    best_idx_d   = best_idx_q;
    best_delay_d = best_delay_q;
    best_due_d   = best_due_q;
    ent_node_d   = ent_node_q;
    ent_fab_d    = ent_fab_q;
    prod_d       = prod_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = mark_slot;
    wr_data_o    = '{node: node_q, fabric: fab_q, due: now_q, delay: DELAY_INIT};
    res_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_e'(in_cmd_i);
          node_d       = in_node_i;
          fab_d        = in_fabric_i;
          now_d        = in_now_i;
          eidx_d       = '0;
          hit_d        = 1'b0;
          free_d       = 1'b0;
          od_d         = 1'b0;
          best_delay_d = '0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        unique case (cmd_q)
          CMD_COMPLETE: begin
            if (ent_match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = eidx_q;
            end
          end
          CMD_MARK: begin
            if (ent_match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = eidx_q;
            end
            if (!ent_used && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = eidx_q;
            end
            // eviction candidate: largest delay, then oldest due time
            if ((eidx_q == '0) || (rd_data_i.delay > best_delay_q) ||
                ((rd_data_i.delay == best_delay_q) && (rd_data_i.due < best_due_q))) begin
              best_idx_d   = eidx_q;
              best_delay_d = rd_data_i.delay;
              best_due_d   = rd_data_i.due;
            end
          end
          CMD_NEXT: begin
            if (ent_used && !hit_q && ent_due) begin
              if (rd_data_i.delay > DELAY_W'(limit_i)) begin
                // timed out: drop and keep looking
                valid_d[eidx_q] = 1'b0;
              end else begin
                hit_d        = 1'b1;
                hit_idx_d    = eidx_q;
                best_delay_d = rd_data_i.delay;
                ent_node_d   = rd_data_i.node;
                ent_fab_d    = rd_data_i.fabric;
              end
            end
          end
          CMD_UNTIL: begin
            if (ent_used && !od_q) begin
              if (ent_due) begin
                od_d         = 1'b1;
                hit_d        = 1'b1;
                best_delay_d = '0;
              end else if (!hit_q || (best_delay_q > diff[MS_W-1:0])) begin
                hit_d        = 1'b1;
                best_delay_d = diff[MS_W-1:0];
              end
            end
          end
          default: begin
          end
        endcase

        // advance to next entry or leave the scan
        if (eidx_q == LAST_IDX) begin
          state_d = (cmd_q == CMD_NEXT) ? ST_CALC : ST_WRITE;
        end else begin
          eidx_d = eidx_q + IW'(1);
        end
      end

      ST_CALC: begin
        prod_d  = PROD_W'(best_delay_q) * PROD_W'(MS_PER_SEC);
        state_d = ST_WRITE;
      end

      ST_WRITE: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
          unique case (cmd_q)
            CMD_CLEAR: begin
              valid_d = '0;
            end
            CMD_COMPLETE: begin
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
              end
            end
            CMD_MARK: begin
              wr_en_o            = 1'b1;
              valid_d[mark_slot] = (node_q != '0);
            end
            CMD_NEXT: begin
              wr_en_o   = hit_q;
              wr_addr_o = hit_idx_q;
              wr_data_o = '{node: ent_node_q, fabric: ent_fab_q,
                            due: now_q + TIME_W'(prod_q), delay: delay_next};
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  // result fields from the scan registers
  always_comb begin
    res_o = '0;
    unique case (cmd_q)
      CMD_COMPLETE: res_o.flag = !hit_q;
      CMD_MARK:     res_o.flag = !hit_q && !free_q;
      CMD_NEXT: begin
        if (hit_q) begin
          res_o.rv     = 1'b1;
          res_o.node   = ent_node_q;
          res_o.fabric = ent_fab_q;
        end
      end
      CMD_UNTIL: begin
        if (hit_q) begin
          res_o.rv       = 1'b1;
          res_o.delay_ms = best_delay_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/resolve_retry_table.sv
// ----------------------------------------------------------------------------
// resolve_retry_table
// Table of pending peer lookups with exponential retry backoff.
// ----------------------------------------------------------------------------
// One command is handled at a time. A command goes from the accepting
// edge through the scan and the write-back state to the result beat, with
// a product state in between for next due peer: the table sits in a
// single RAM with one read port, and the scan reads one entry per cycle
// before the chosen entry is written back. The result sits in an output
// register, and the next command is accepted while it waits to be taken.
// The retry limit may be written at any time the block is idle; reset
// leaves every slot unused and the limit at 16 seconds.
module resolve_retry_table
  import rrt_pkg::*;
#(
  parameter int unsigned ENTRIES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // retry limit register
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  // command stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [191:0]       s_axis_tdata_i,   // peer_node_id, peer_fabric_id, now_ms
  input  logic [2:0]         s_axis_tuser_i,   // cmd
  // result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [159:0]       m_axis_tdata_o,   // delay_ms, out_node_id, out_fabric_id
  output logic [1:0]         m_axis_tuser_o    // result_valid, status_flag
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [LIMIT_W-1:0] limit_q;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               out_valid_q;
  res_t               out_q;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic               wr_en;
  entry_t             wr_data;
  logic [$bits(entry_t)-1:0] rd_word;

  // retry limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  rrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  rrt_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_node_i   (s_axis_tdata_i[63:0]),
    .in_fabric_i (s_axis_tdata_i[127:64]),
    .in_now_i    (s_axis_tdata_i[191:128]),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (entry_t'(rd_word)),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // output register: load a new result, drop a taken one
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.fabric, out_q.node, out_q.delay_ms};
  assign m_axis_tuser_o  = {out_q.flag, out_q.rv};

endmodule

>>> rtl/rrt_checker.sv
// ----------------------------------------------------------------------------
// rrt_checker
// Port-level checks on the resolve retry table, bound to the top level.
// ----------------------------------------------------------------------------
module rrt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [159:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  // one command in flight: no beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted while another is in flight");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  // without a returned peer or delay, the data fields are zero
  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("data present without result_valid");

  // status flag never comes with result_valid; it only comes with complete or mark pending
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("status flag together with result_valid");

endmodule

bind resolve_retry_table rrt_checker u_rrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> bench/tb_resolve_retry_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resolve_retry_table
// Checks the retry table against an in-bench model of its slots, retry
// delays and due times. Every command is predicted when its beat is taken
// and its one result beat is compared field by field in order. Directed
// commands cover the empty table, node id zero, unknown commands,
// eviction, reuse and a zero retry limit. Random phases then drive a small
// pool of peers over advancing time under several retry limits, with
// bursty commands and a stalling result side.
// ----------------------------------------------------------------------------
module tb_resolve_retry_table;
  import rrt_pkg::*;

  localparam int unsigned NSLOTS = 4;
  localparam int unsigned NPEERS = 6;

  // command codes beyond the defined set, handled as no-ops
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = CMD_W'(7);

  localparam logic [LIMIT_W-1:0] LIMIT_TOP = LIMIT_W'(1048576);
  localparam logic [ID_W-1:0]    ID_A5     = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [ID_W-1:0]    ID_5A     = 64'h5555_5555_5555_5555;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata  = '0;
  logic               cmd_tvalid = 1'b0;
  logic               cmd_tready;
  logic [191:0]       cmd_tdata  = '0;   // peer_node_id, peer_fabric_id, now_ms
  logic [2:0]         cmd_tuser  = '0;   // cmd
  logic               res_tvalid;
  logic               res_tready = 1'b0;
  logic [159:0]       res_tdata;         // delay_ms, out_node_id, out_fabric_id
  logic [1:0]         res_tuser;         // result_valid, status_flag

  // model of the table
  logic [ID_W-1:0]    slot_node  [NSLOTS] = '{default: '0};
  logic [ID_W-1:0]    slot_fab   [NSLOTS] = '{default: '0};
  logic [TIME_W-1:0]  slot_due   [NSLOTS] = '{default: '0};
  logic [DELAY_W-1:0] slot_delay [NSLOTS] = '{default: '0};
  logic [LIMIT_W-1:0] retry_limit = LIMIT_RST;

  res_t predicted_replies [$];
  res_t want_reply;
  int   error_count = 0;

  // sender burst control
  int burst_left = 0;
  bit idle_on    = 1'b1;

  // peer pool for the random phases
  logic [ID_W-1:0] pool_node [NPEERS];
  logic [ID_W-1:0] pool_fab  [NPEERS];

  // receiver stall pattern
  logic [15:0] stall_pat = 16'hFFFF;
  logic [6:0]  stall_age = '0;

  resolve_retry_table #(
    .ENTRIES (NSLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .s_axis_tdata_i  (cmd_tdata),
    .s_axis_tuser_i  (cmd_tuser),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tuser_o  (res_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Rotate the stall pattern, reload it each time the age counter wraps
  always @(posedge clk_i) begin
    stall_age <= stall_age + 7'd1;
    if (stall_age == '0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    res_tready <= stall_pat[15];
  end

  function automatic bit slot_matches(input int i, input logic [ID_W-1:0] node,
                                      input logic [ID_W-1:0] fab);
    return node != '0 && slot_node[i] == node && slot_fab[i] == fab;
  endfunction

  // Apply one command to the table model and return its result beat
  function automatic res_t apply_table_cmd(input logic [CMD_W-1:0]  op,
                                           input logic [ID_W-1:0]   node,
                                           input logic [ID_W-1:0]   fab,
                                           input logic [TIME_W-1:0] now);
    res_t               r;
    int                 i;
    int                 s;
    bit                 hit;
    bit                 overdue;
    logic [MS_W-1:0]    best;
    logic [MS_W-1:0]    gap_ms;
    r = '0;
    case (op)
      CMD_CLEAR: begin
        for (i = 0; i < NSLOTS; i++) slot_node[i] = '0;
      end
      CMD_COMPLETE: begin
        r.flag = 1'b1;
        for (i = 0; i < NSLOTS; i++) begin
          if (r.flag && slot_matches(i, node, fab)) begin
            slot_node[i] = '0;
            r.flag       = 1'b0;
          end
        end
      end
      CMD_MARK: begin
        // matching slot, else first unused, else the costliest to lose
        s = -1;
        for (i = 0; i < NSLOTS; i++) if (s < 0 && slot_matches(i, node, fab)) s = i;
        for (i = 0; i < NSLOTS; i++) if (s < 0 && slot_node[i] == '0) s = i;
        if (s < 0) begin
          s = 0;
          for (i = 1; i < NSLOTS; i++) begin
            if (slot_delay[i] > slot_delay[s] ||
                (slot_delay[i] == slot_delay[s] && slot_due[i] < slot_due[s])) s = i;
          end
        end
        r.flag        = slot_node[s] != '0 && !slot_matches(s, node, fab);
        slot_node[s]  = node;
        slot_fab[s]   = fab;
        slot_due[s]   = now;
        slot_delay[s] = DELAY_INIT;
      end
      CMD_NEXT: begin
        hit = 1'b0;
        for (i = 0; i < NSLOTS; i++) begin
          if (!hit && slot_node[i] != '0 && slot_due[i] <= now) begin
            if (slot_delay[i] > DELAY_W'(retry_limit)) begin
              slot_node[i] = '0;
            end else begin
              slot_due[i]   = now + 64'(slot_delay[i]) * 64'(MS_PER_SEC);
              slot_delay[i] = (slot_delay[i] >= 32'h8000_0000) ? DELAY_MAX
                                                               : slot_delay[i] << 1;
              r.rv     = 1'b1;
              r.node   = slot_node[i];
              r.fabric = slot_fab[i];
              hit      = 1'b1;
            end
          end
        end
      end
      CMD_UNTIL: begin
        hit     = 1'b0;
        overdue = 1'b0;
        best    = '0;
        for (i = 0; i < NSLOTS; i++) begin
          if (!overdue && slot_node[i] != '0) begin
            if (now >= slot_due[i]) begin
              overdue = 1'b1;
              hit     = 1'b1;
              best    = '0;
            end else begin
              gap_ms = MS_W'(slot_due[i] - now);
              if (!hit || best > gap_ms) best = gap_ms;
              hit = 1'b1;
            end
          end
        end
        r.rv       = hit;
        r.delay_ms = best;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    error_count++;
    // keep the log short when everything goes wrong
    if (error_count <= 40)
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (res_tvalid && res_tready) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected result beat", res_tdata[95:32], '0);
      end else begin
        want_reply = predicted_replies.pop_front();
        if (res_tuser[0] !== want_reply.rv)
          report_mismatch("result_valid", res_tuser[0], want_reply.rv);
        if (res_tuser[1] !== want_reply.flag)
          report_mismatch("status_flag", res_tuser[1], want_reply.flag);
        if (res_tdata[31:0] !== want_reply.delay_ms)
          report_mismatch("delay_ms", res_tdata[31:0], want_reply.delay_ms);
        if (res_tdata[95:32] !== want_reply.node)
          report_mismatch("out_node_id", res_tdata[95:32], want_reply.node);
        if (res_tdata[159:96] !== want_reply.fabric)
          report_mismatch("out_fabric_id", res_tdata[159:96], want_reply.fabric);
      end
    end
  end

  // Send one command beat, idling between bursts when idle_on is set, and predict its result
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] node,
                          input logic [ID_W-1:0] fab, input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = idle_on ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        cmd_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_tvalid <= 1'b1;
    cmd_tuser  <= op;
    cmd_tdata  <= {now, fab, node};
    do @(posedge clk_i); while (!cmd_tready);
    predicted_replies.push_back(apply_table_cmd(op, node, fab, now));
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_idle();
    cmd_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (predicted_replies.size() != 0);
  endtask

  task automatic write_retry_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    retry_limit = value;
  endtask

  // Empty table: nothing due, nothing to complete
  task automatic test_empty_table();
    send_cmd(CMD_NEXT, '0, '0, '0);
    send_cmd(CMD_UNTIL, '0, '0, '1);
    send_cmd(CMD_COMPLETE, 64'd1, '0, '0);
  endtask

  // Node id zero never occupies or matches a slot
  task automatic test_node_zero();
    send_cmd(CMD_MARK, '0, '1, '0);
    send_cmd(CMD_COMPLETE, '0, '1, '0);
    send_cmd(CMD_UNTIL, '0, '0, '0);
  endtask

  task automatic test_unknown_cmds();
    logic [CMD_W-1:0] op;
    for (op = CMD_RSVD_LO; op != CMD_RSVD_HI; op++) send_cmd(op, '1, '1, '1);
    send_cmd(CMD_RSVD_HI, '1, '1, '1);
  endtask

  // Fill the table, back off one peer, evict it, reuse and complete peers
  task automatic test_evict_and_reuse();
    send_cmd(CMD_MARK, '1, '1, 64'd1000);
    send_cmd(CMD_MARK, 64'd1, '0, 64'd500);
    send_cmd(CMD_MARK, ID_A5, ID_5A, 64'd2000);
    send_cmd(CMD_MARK, ID_5A, ID_A5, '1);
    send_cmd(CMD_NEXT, '0, '0, 64'd1000);
    send_cmd(CMD_UNTIL, '0, '0, 64'd100);
    send_cmd(CMD_MARK, 64'd7, 64'd9, 64'd3000);
    send_cmd(CMD_MARK, 64'd1, '0, 64'd10);
    send_cmd(CMD_COMPLETE, ID_A5, ID_5A, '0);
    send_cmd(CMD_COMPLETE, ID_A5, ID_5A, '0);
    send_cmd(CMD_UNTIL, '0, '0, 64'd20);
  endtask

  // A zero limit times out every due entry
  task automatic test_zero_limit();
    write_retry_limit('0);
    send_cmd(CMD_MARK, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0);
    send_cmd(CMD_NEXT, '0, '0, 64'd5);
    send_cmd(CMD_CLEAR, '0, '0, '0);
    send_cmd(CMD_UNTIL, '0, '0, '0);
  endtask

  // Random traffic from a small peer pool over advancing time
  task automatic test_random_phase(input logic [LIMIT_W-1:0] limit, input int count,
                                   input bit idle, input bit pause_midway);
    logic [TIME_W-1:0] clock_ms;
    logic [CMD_W-1:0]  op;
    int                k;
    int                pick;
    int                roll;
    write_retry_limit(limit);
    idle_on = idle;
    for (k = 0; k < NPEERS; k++) begin
      pool_node[k] = {$urandom, $urandom};
      pool_fab[k]  = {$urandom, $urandom};
    end
    // same node on two fabrics
    pool_node[1] = pool_node[0];
    if ($urandom_range(0, 1) == 0) pool_node[NPEERS-1] = '0;
    // start near the top of time now and then so due times wrap
    clock_ms = ($urandom_range(0, 3) == 0) ? '1 - 64'($urandom_range(0, 200000))
                                           : 64'($urandom);
    for (k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) wait_idle();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any command, any fields, any time
        send_cmd(CMD_W'($urandom_range(CMD_CLEAR, CMD_RSVD_HI)), {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        pick = $urandom_range(0, NPEERS - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: clock_ms += 64'($urandom_range(0, 2500));
          4, 5, 6:    clock_ms += 64'($urandom_range(0, 40000));
          7:          clock_ms += 64'($urandom) << $urandom_range(0, 24);
          default: ;
        endcase
        if (roll < 36)      op = CMD_MARK;
        else if (roll < 66) op = CMD_NEXT;
        else if (roll < 80) op = CMD_UNTIL;
        else if (roll < 95) op = CMD_COMPLETE;
        else if (roll < 97) op = CMD_CLEAR;
        else                op = CMD_RSVD_LO + CMD_W'($urandom_range(0, 2));
        send_cmd(op, pool_node[pick], pool_fab[pick], clock_ms);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_node_zero();
    test_unknown_cmds();
    test_evict_and_reuse();
    test_zero_limit();

    test_random_phase(LIMIT_RST, 265, 1'b1, 1'b0);
    test_random_phase(LIMIT_W'(1), 265, 1'b1, 1'b1);
    test_random_phase(LIMIT_TOP, 265, 1'b0, 1'b0);
    test_random_phase(LIMIT_W'($urandom_range(2, 64)), 265, 1'b1, 1'b0);
    test_random_phase('1, 265, 1'b1, 1'b0);
    test_random_phase('0, 265, 1'b1, 1'b0);

    // drain, then keep watching for stray beats
    wait_idle();
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
